/* hdl/acd_pkg.sv */
// ----------------------------------------------------------------------------
// acd_pkg
// Shared types, register indexes and cube geometry for the active cube
// detector.
// ----------------------------------------------------------------------------
package acd_pkg;

  localparam int MAX_X_DEF       = 128;
  localparam int MAX_Y_DEF       = 128;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_Z           = 4096;
  localparam int ZW              = 12;
  localparam int EZW             = 13;
  localparam int ISO_W           = 16;
  localparam int APB_AW          = 4;
  localparam int APB_DW          = 32;

  typedef enum logic [1:0] {
    REG_SIZE_X    = 2'd0,
    REG_SIZE_Y    = 2'd1,
    REG_SIZE_Z    = 2'd2,
    REG_ISO_LEVEL = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0]              size_x;
    logic [7:0]              size_y;
    logic [12:0]             size_z;
    logic signed [ISO_W-1:0] iso_level;
  } cfg_t;

  localparam logic [2:0] EDGE_A [12] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
                                         3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3};
  localparam logic [2:0] EDGE_B [12] = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6,
                                         3'd7, 3'd4, 3'd4, 3'd5, 3'd6, 3'd7};

endpackage

/* hdl/acd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// acd_cfg_regs
// APB register bank holding the volume sizes and the isovalue.
// ----------------------------------------------------------------------------
module acd_cfg_regs import acd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_index_t idx;

  assign idx    = reg_index_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_x    <= 8'd128;
      cfg.size_y    <= 8'd128;
      cfg.size_z    <= 13'd128;
      cfg.iso_level <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        REG_SIZE_X:    cfg.size_x    <= pwdata[7:0];
        REG_SIZE_Y:    cfg.size_y    <= pwdata[7:0];
        REG_SIZE_Z:    cfg.size_z    <= pwdata[12:0];
        REG_ISO_LEVEL: cfg.iso_level <= pwdata[ISO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SIZE_X:    prdata = APB_DW'(cfg.size_x);
      REG_SIZE_Y:    prdata = APB_DW'(cfg.size_y);
      REG_SIZE_Z:    prdata = APB_DW'(cfg.size_z);
      REG_ISO_LEVEL: prdata = APB_DW'(unsigned'(cfg.iso_level));
      default:       prdata = '0;
    endcase
  end

endmodule

/* hdl/acd_slice_mem.sv */
// ----------------------------------------------------------------------------
// acd_slice_mem
// Slice store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module acd_slice_mem import acd_pkg::*; #(
  parameter int AW = 14,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [DW-1:0] rd_data_a,
  output logic [DW-1:0] rd_data_b,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

/* hdl/acd_edge_test.sv */
// ----------------------------------------------------------------------------
// acd_edge_test
// Tests every edge of a cube for a strict crossing of the isovalue.
// ----------------------------------------------------------------------------
module acd_edge_test import acd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic signed [SAMPLE_BITS-1:0] corner [8],
  input  logic signed [ISO_W-1:0]       iso_level,
  output logic                          active
);

  localparam int CW = (SAMPLE_BITS > ISO_W) ? SAMPLE_BITS : ISO_W;

  logic signed [CW-1:0] iso_ext;
  logic [7:0]           lt;
  logic [7:0]           gt;

  assign iso_ext = CW'(iso_level);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      lt[i] = CW'(corner[i]) < iso_ext;
      gt[i] = CW'(corner[i]) > iso_ext;
    end
    active = 1'b0;
    for (int e = 0; e < 12; e++) begin
      active = active | (lt[EDGE_A[e]] & gt[EDGE_B[e]]) | (gt[EDGE_A[e]] & lt[EDGE_B[e]]);
    end
  end

endmodule

/* hdl/active_cube_detector_unit.sv */
// ----------------------------------------------------------------------------
// active_cube_detector_unit
// Streams voxel samples in raster order and reports every active unit cube.
// ----------------------------------------------------------------------------
// The block takes one sample per clock cycle unless the output stalls, and a
// request for an active cube is registered in the s1 stage, then in the output
// register. Each sample makes two reads of the slice store, one at its own
// column of the current row and one at the row below, and one write back from
// the s1 stage; each store word holds a column's samples of the last two z
// slices. The four corners of the previous column are kept in registers. The
// store is not cleared after reset, so it needs no initialization pass.
// ----------------------------------------------------------------------------
module active_cube_detector_unit import acd_pkg::*; #(
  parameter int MAX_X       = MAX_X_DEF,
  parameter int MAX_Y       = MAX_Y_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int XW  = $clog2(MAX_X),
  localparam int YW  = $clog2(MAX_Y),
  localparam int ITW = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OTW = ((XW + YW + ZW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  // s_tdata: sample
  input  logic [ITW-1:0]    s_tdata,
  // s_tuser: volume_start
  input  logic              s_tuser,
  input  logic              s_tvalid,
  output logic              s_tready,
  // m_tdata: cube_x, cube_y, cube_z
  output logic [OTW-1:0]    m_tdata,
  output logic              m_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int EXW = $clog2(MAX_X + 1);
  localparam int EYW = $clog2(MAX_Y + 1);
  localparam int AW  = XW + YW;
  localparam int W   = SAMPLE_BITS;

  cfg_t cfg;

  logic [EXW-1:0] ex;
  logic [EYW-1:0] ey;
  logic [EZW-1:0] ez;
  logic [15:0]    sx_w;
  logic [15:0]    sy_w;
  logic [15:0]    sz_w;

  logic [XW-1:0] pos_x;
  logic [YW-1:0] pos_y;
  logic [ZW-1:0] pos_z;
  logic [XW-1:0] pos_x_next;
  logic [YW-1:0] pos_y_next;
  logic [ZW-1:0] pos_z_next;
  logic [XW-1:0] px;
  logic [YW-1:0] py;
  logic [ZW-1:0] pz;
  logic          wrap_x;
  logic          wrap_y;
  logic          wrap_z;
  logic          cube_ok;
  logic          accept;

  logic                 s1_valid;
  logic signed [W-1:0]  s1_sample;
  logic                 s1_cube;
  logic                 s1_final;
  logic [XW-1:0]        s1_x;
  logic [YW-1:0]        s1_y;
  logic [ZW-1:0]        s1_z;
  logic [AW-1:0]        s1_addr;
  logic                 s1_go;

  logic [2*W-1:0] rd_data_a;
  logic [2*W-1:0] rd_data_b;

  logic signed [W-1:0] prev_c1;
  logic signed [W-1:0] prev_c2;
  logic signed [W-1:0] prev_c5;
  logic signed [W-1:0] prev_c6;
  logic signed [W-1:0] corner [8];
  logic                active;

  logic [XW-1:0] out_x;
  logic [YW-1:0] out_y;
  logic [ZW-1:0] out_z;

  acd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign sx_w = {8'd0, cfg.size_x};
  assign sy_w = {8'd0, cfg.size_y};
  assign sz_w = {3'd0, cfg.size_z};

  always_comb begin
    if (sx_w < 16'd2) ex = EXW'(2);
    else if (sx_w > 16'(MAX_X)) ex = EXW'(MAX_X);
    else ex = sx_w[EXW-1:0];
    if (sy_w < 16'd2) ey = EYW'(2);
    else if (sy_w > 16'(MAX_Y)) ey = EYW'(MAX_Y);
    else ey = sy_w[EYW-1:0];
    if (sz_w < 16'd2) ez = EZW'(2);
    else if (sz_w > 16'(MAX_Z)) ez = EZW'(MAX_Z);
    else ez = sz_w[EZW-1:0];
  end

  assign accept   = s_tvalid && s_tready;
  assign s1_go    = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_go;

  assign px = s_tuser ? '0 : pos_x;
  assign py = s_tuser ? '0 : pos_y;
  assign pz = s_tuser ? '0 : pos_z;

  assign wrap_x = EXW'(px) >= ex - EXW'(1);
  assign wrap_y = EYW'(py) >= ey - EYW'(1);
  assign wrap_z = EZW'(pz) >= ez - EZW'(1);

  assign cube_ok = (px != '0) && (py != '0) && (pz != '0) &&
                   (EXW'(px) < ex) && (EYW'(py) < ey) && (EZW'(pz) < ez);

  always_comb begin
    pos_x_next = px + XW'(1);
    pos_y_next = py;
    pos_z_next = pz;
    if (wrap_x) begin
      pos_x_next = '0;
      pos_y_next = py + YW'(1);
      if (wrap_y) begin
        pos_y_next = '0;
        pos_z_next = wrap_z ? '0 : pz + ZW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (accept) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      pos_z <= pos_z_next;
    end
  end

  acd_slice_mem #(
    .AW (AW),
    .DW (2 * W)
  ) u_mem (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr_a ({py, px}),
    .rd_addr_b ({py - YW'(1), px}),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr_en     (s1_go),
    .wr_addr   (s1_addr),
    .wr_data   ({s1_sample, rd_data_a[2*W-1:W]})
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= s_tdata[W-1:0];
      s1_cube   <= cube_ok;
      s1_final  <= (EXW'(px) == ex - EXW'(1)) && (EYW'(py) == ey - EYW'(1)) &&
                   (EZW'(pz) == ez - EZW'(1));
      s1_x      <= px - XW'(1);
      s1_y      <= py - YW'(1);
      s1_z      <= pz - ZW'(1);
      s1_addr   <= {py, px};
    end
  end

  assign corner[0] = prev_c1;
  assign corner[1] = rd_data_b[W-1:0];
  assign corner[2] = rd_data_a[2*W-1:W];
  assign corner[3] = prev_c2;
  assign corner[4] = prev_c5;
  assign corner[5] = rd_data_b[2*W-1:W];
  assign corner[6] = s1_sample;
  assign corner[7] = prev_c6;

  acd_edge_test #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_edge (
    .corner    (corner),
    .iso_level (cfg.iso_level),
    .active    (active)
  );

  always_ff @(posedge clk) begin
    if (s1_go) begin
      prev_c1 <= corner[1];
      prev_c2 <= corner[2];
      prev_c5 <= corner[5];
      prev_c6 <= corner[6];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go) begin
      m_tvalid <= s1_cube && active;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_x   <= s1_x;
      out_y   <= s1_y;
      out_z   <= s1_z;
      m_tlast <= s1_final;
    end
  end

  assign m_tdata = OTW'({out_z, out_y, out_x});

endmodule
